// ===== hw/rtl/wvs_pkg.sv =====
// ----------------------------------------------------------------------------
// wvs_pkg: shared types and constants for the vertex skinning core
// Fixed field widths, the sequencer state type and the command codes.
// ----------------------------------------------------------------------------
package wvs_pkg;

    localparam int VEC_W  = 32;
    localparam int QUAT_W = 16;
    localparam int BIAS_W = 16;
    localparam int SUM_W  = 64;
    localparam int MAT_W  = 33;   // Q.28 matrix entry
    localparam int PROD_W = 65;   // matrix entry times offset component
    localparam int ROW_W  = 67;   // sum of three products

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAT,
        ST_PROD,
        ST_ROW,
        ST_SCALE,
        ST_ACC,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/weighted_vertex_skinning_core.sv =====
// ----------------------------------------------------------------------------
// weighted_vertex_skinning_core
// Quaternion skinning with a joint palette held in synchronous memory.
// ----------------------------------------------------------------------------
// A load item writes one palette entry when accepted. A weight item steps
// through these states in order: registered palette read, rotation matrix build,
// three row products, row sum and round, bias scale, saturating accumulate,
// and for a last weight an emit state that presents the vertex in the output
// register. The sequencer handles one item at a time; the output register lets
// the next item start while a vertex waits to be taken. The palette is not
// cleared at reset; a weight must only name joints that were loaded.
module weighted_vertex_skinning_core #(
    parameter int MAX_JOINTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: cmd, joint_index[6], vec_x, vec_y, vec_z,
    // quat_x, quat_y, quat_z, quat_w, bias; zero padded to 184 bits
    input  logic [183:0] s_tdata,
    input  logic         s_tlast,    // last_weight
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: vert_x, vert_y, vert_z
    output logic [95:0]  m_tdata
);
    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    logic [wvs_pkg::VEC_W-1:0] mem_px [MAX_JOINTS];
    logic [wvs_pkg::VEC_W-1:0] mem_py [MAX_JOINTS];
    logic [wvs_pkg::VEC_W-1:0] mem_pz [MAX_JOINTS];
    logic [63:0]               mem_q  [MAX_JOINTS];

    logic        in_cmd;
    logic [5:0]  in_idx;
    logic [7:0]  in_idx_w;
    logic signed [31:0] in_vx, in_vy, in_vz;
    logic signed [15:0] in_qx, in_qy, in_qz, in_qw;
    logic [15:0] in_bias;
    logic        idx_ok;
    logic        accept;

    assign in_cmd  = s_tdata[0];
    assign in_idx  = s_tdata[6:1];
    assign in_vx   = s_tdata[38:7];
    assign in_vy   = s_tdata[70:39];
    assign in_vz   = s_tdata[102:71];
    assign in_qx   = s_tdata[118:103];
    assign in_qy   = s_tdata[134:119];
    assign in_qz   = s_tdata[150:135];
    assign in_qw   = s_tdata[166:151];
    assign in_bias = s_tdata[182:167];
    assign in_idx_w = {2'b00, in_idx};
    assign idx_ok  = ({1'b0, in_idx_w} < 9'(MAX_JOINTS));

    function automatic logic [15:0] clampq(input logic signed [15:0] v);
        logic [15:0] r;
        if (v > 16'sd16384) r = 16'd16384;
        else if (v < -16'sd16384) r = 16'hC000;
        else r = v;
        return r;
    endfunction

    wvs_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic signed [63:0] sum_reg [3];

    // item payload held during a weight
    logic [AW-1:0]      idx_reg;
    logic               ok_reg, last_reg;
    logic signed [31:0] off_reg [3];
    logic [15:0]        bias_reg;

    // pipeline registers
    logic signed [31:0] rp_reg [3];
    logic [63:0]        rq_reg;
    logic signed [wvs_pkg::MAT_W-1:0]  mat_reg  [9];
    logic signed [wvs_pkg::PROD_W-1:0] prod_reg [9];
    logic signed [34:0] r_reg   [3];
    logic signed [51:0] sc_reg  [3];
    logic [95:0]        out_reg;

    assign s_tready = aresetn && (state_reg == wvs_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        unique case (state_reg)
            wvs_pkg::ST_IDLE: begin
                if (accept && in_cmd == wvs_pkg::CMD_WEIGHT) state_next = wvs_pkg::ST_READ;
            end
            wvs_pkg::ST_READ:  state_next = wvs_pkg::ST_MAT;
            wvs_pkg::ST_MAT:   state_next = wvs_pkg::ST_PROD;
            wvs_pkg::ST_PROD:  state_next = wvs_pkg::ST_ROW;
            wvs_pkg::ST_ROW:   state_next = wvs_pkg::ST_SCALE;
            wvs_pkg::ST_SCALE: state_next = wvs_pkg::ST_ACC;
            wvs_pkg::ST_ACC:   state_next = last_reg ? wvs_pkg::ST_EMIT : wvs_pkg::ST_IDLE;
            wvs_pkg::ST_EMIT: begin
                // hold until the previous vertex leaves the output register
                if (!m_valid_reg || m_tready) begin
                    state_next   = wvs_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = wvs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wvs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // palette memory: write on load, registered read on weight
    always_ff @(posedge aclk) begin
        if (accept && in_cmd == wvs_pkg::CMD_LOAD && idx_ok) begin
            mem_px[in_idx_w[AW-1:0]] <= in_vx;
            mem_py[in_idx_w[AW-1:0]] <= in_vy;
            mem_pz[in_idx_w[AW-1:0]] <= in_vz;
            mem_q[in_idx_w[AW-1:0]]  <= {clampq(in_qw), clampq(in_qz),
                                         clampq(in_qy), clampq(in_qx)};
        end
        if (state_reg == wvs_pkg::ST_READ) begin
            rp_reg[0] <= mem_px[idx_reg];
            rp_reg[1] <= mem_py[idx_reg];
            rp_reg[2] <= mem_pz[idx_reg];
            rq_reg    <= mem_q[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg   <= in_idx_w[AW-1:0];
            ok_reg    <= idx_ok;
            last_reg  <= s_tlast;
            off_reg[0] <= in_vx;
            off_reg[1] <= in_vy;
            off_reg[2] <= in_vz;
            bias_reg  <= in_bias;
        end
    end

    // quaternion products: 16x16 each, summed into Q.28 entries
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [31:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
    assign qx = rq_reg[15:0];
    assign qy = rq_reg[31:16];
    assign qz = rq_reg[47:32];
    assign qw = rq_reg[63:48];
    assign xx = qx * qx;  assign yy = qy * qy;  assign zz = qz * qz;
    assign ww = qw * qw;  assign xy = qx * qy;  assign xz = qx * qz;
    assign yz = qy * qz;  assign wx = qw * qx;  assign wy = qw * qy;
    assign wz = qw * qz;

    function automatic logic signed [32:0] sx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    always_ff @(posedge aclk) begin
        if (state_reg == wvs_pkg::ST_MAT) begin
            mat_reg[0] <= sx(ww) + sx(xx) - sx(yy) - sx(zz);
            mat_reg[1] <= (sx(xy) - sx(wz)) <<< 1;
            mat_reg[2] <= (sx(xz) + sx(wy)) <<< 1;
            mat_reg[3] <= (sx(xy) + sx(wz)) <<< 1;
            mat_reg[4] <= sx(ww) - sx(xx) + sx(yy) - sx(zz);
            mat_reg[5] <= (sx(yz) - sx(wx)) <<< 1;
            mat_reg[6] <= (sx(xz) - sx(wy)) <<< 1;
            mat_reg[7] <= (sx(yz) + sx(wx)) <<< 1;
            mat_reg[8] <= sx(ww) - sx(xx) - sx(yy) + sx(zz);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == wvs_pkg::ST_PROD) begin
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= mat_reg[i] * off_reg[i % 3];
            end
        end
    end

    logic signed [wvs_pkg::ROW_W-1:0] row_sum [3];
    logic signed [wvs_pkg::ROW_W-1:0] row_shr [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = wvs_pkg::ROW_W'(prod_reg[3*r]) + wvs_pkg::ROW_W'(prod_reg[3*r+1])
                       + wvs_pkg::ROW_W'(prod_reg[3*r+2]) + (wvs_pkg::ROW_W'(1) <<< 27);
            row_shr[r] = row_sum[r] >>> 28;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == wvs_pkg::ST_ROW) begin
            for (int r = 0; r < 3; r++) begin
                r_reg[r] <= 35'(row_shr[r]) + 35'(rp_reg[r]);
            end
        end
        if (state_reg == wvs_pkg::ST_SCALE) begin
            for (int r = 0; r < 3; r++) begin
                sc_reg[r] <= ok_reg ? 52'(r_reg[r] * $signed({1'b0, bias_reg})) : 52'sd0;
            end
        end
    end

    // saturating accumulate; clear when a finished vertex moves to the output register
    logic signed [64:0] acc_wide [3];
    logic signed [63:0] acc_sat  [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc_wide[r] = 65'(sum_reg[r]) + 65'(sc_reg[r]);
            if (acc_wide[r][64] != acc_wide[r][63])
                acc_sat[r] = acc_wide[r][64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                acc_sat[r] = acc_wide[r][63:0];
        end
    end

    logic signed [63:0] em_s   [3];
    logic signed [63:0] em_shr [3];
    logic [31:0]        em_v   [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            em_s[r] = (sum_reg[r] > 64'sh7FFF_FFFF_FFFF_BFFF) ? 64'sh7FFF_FFFF_FFFF_BFFF
                                                              : sum_reg[r];
            em_shr[r] = (em_s[r] + 64'sd16384) >>> 15;
            if (em_shr[r] > 64'sd2147483647) em_v[r] = 32'h7FFF_FFFF;
            else if (em_shr[r] < -64'sd2147483648) em_v[r] = 32'h8000_0000;
            else em_v[r] = em_shr[r][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) sum_reg[r] <= '0;
        end else if (state_reg == wvs_pkg::ST_ACC) begin
            for (int r = 0; r < 3; r++) sum_reg[r] <= acc_sat[r];
        end else if (state_reg == wvs_pkg::ST_EMIT && state_next == wvs_pkg::ST_IDLE) begin
            for (int r = 0; r < 3; r++) sum_reg[r] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == wvs_pkg::ST_EMIT && state_next == wvs_pkg::ST_IDLE)
            out_reg <= {em_v[2], em_v[1], em_v[0]};
    end

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != wvs_pkg::ST_IDLE |-> !s_tready)
        else $error("ready while a weight is in flight");
    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wvs_pkg::ST_EMIT && state_next == wvs_pkg::ST_IDLE) |=> m_tvalid)
        else $error("vertex not presented");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output changed while stalled");
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wvs_pkg::ST_EMIT && state_next == wvs_pkg::ST_IDLE) |=>
        (sum_reg[0] == 64'sd0 && sum_reg[1] == 64'sd0 && sum_reg[2] == 64'sd0))
        else $error("accumulators not cleared");
endmodule

// ===== verif/skin_checker.sv =====
// ----------------------------------------------------------------------------
// skin_checker
// Watches both streams of the skinning core, keeps its own palette and
// accumulators, predicts each finished vertex and compares it with the output.
// ----------------------------------------------------------------------------
module skin_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [183:0] s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    output int           fail_count,
    output int           vertices_pending
);
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    logic signed [31:0] pal_px [64];
    logic signed [31:0] pal_py [64];
    logic signed [31:0] pal_pz [64];
    logic signed [15:0] pal_q  [64][4];   // x, y, z, w
    longint acc_x, acc_y, acc_z;
    logic [95:0] vertex_queue [$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] clamp_q(logic signed [15:0] v);
        if (v > 16'sd16384) return 16'sd16384;
        if (v < -16'sd16384) return -16'sd16384;
        return v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S64_MAX)) return S64_MAX;
        if (s < 65'(S64_MIN)) return S64_MIN;
        return a + b;
    endfunction

    function automatic longint rot_row(longint a, longint b, longint c,
                                       longint vx, longint vy, longint vz);
        longint sum;
        sum = a * vx + b * vy + c * vz;
        return floor_shr(sum + (64'sd1 <<< 27), 28);
    endfunction

    function automatic logic [31:0] round_out(longint s);
        longint r;
        if (s > S64_MAX - 16384) s = S64_MAX - 16384;
        r = floor_shr(s + 16384, 15);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic apply_item(logic [183:0] d, logic last);
        int j;
        longint vx, vy, vz, x, y, z, w, b, rx, ry, rz;
        j  = d[6:1];
        vx = longint'($signed(d[38:7]));
        vy = longint'($signed(d[70:39]));
        vz = longint'($signed(d[102:71]));
        if (d[0] == wvs_pkg::CMD_LOAD) begin
            pal_px[j] = vx;
            pal_py[j] = vy;
            pal_pz[j] = vz;
            for (int k = 0; k < 4; k++)
                pal_q[j][k] = clamp_q($signed(d[103 + 16 * k +: 16]));
            return;
        end
        x = pal_q[j][0];
        y = pal_q[j][1];
        z = pal_q[j][2];
        w = pal_q[j][3];
        b = longint'(d[182:167]);
        rx = rot_row(w*w + x*x - y*y - z*z, 2*(x*y - w*z), 2*(x*z + w*y), vx, vy, vz);
        ry = rot_row(2*(x*y + w*z), w*w - x*x + y*y - z*z, 2*(y*z - w*x), vx, vy, vz);
        rz = rot_row(2*(x*z - w*y), 2*(y*z + w*x), w*w - x*x - y*y + z*z, vx, vy, vz);
        acc_x = sat_add(acc_x, (rx + pal_px[j]) * b);
        acc_y = sat_add(acc_y, (ry + pal_py[j]) * b);
        acc_z = sat_add(acc_z, (rz + pal_pz[j]) * b);
        if (last) begin
            vertex_queue.push_back({round_out(acc_z), round_out(acc_y), round_out(acc_x)});
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
        end
    endtask

    always @(posedge aclk) begin
        logic [95:0] want;
        if (!aresetn) begin
            fail_count = 0;
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            vertex_queue.delete();
            vertices_pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (vertex_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected vertex %h", m_tdata);
                end else begin
                    want = vertex_queue.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        if (want[32 * k +: 32] !== m_tdata[32 * k +: 32]) begin
                            fail_count++;
                            if (fail_count <= 10)
                                $display("vert[%0d] expected %h got %h", k,
                                         want[32 * k +: 32], m_tdata[32 * k +: 32]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_item(s_tdata, s_tlast);
            vertices_pending = vertex_queue.size();
        end
    end
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives joint loads and weight runs into the skinning core with random
// gaps and output stalls; the checker predicts and compares every vertex.
// ----------------------------------------------------------------------------
module testbench;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    int           fail_count;
    int           vertices_pending;
    int           cycle_count = 0;
    bit           quiet_stretch = 1'b0;
    bit           loaded [64];

    always #6 aclk = ~aclk;

    weighted_vertex_skinning_core dut (.*);

    skin_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_tready <= quiet_stretch || ($urandom_range(99) >= 19);
        if (cycle_count > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] pick_quat();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);           // out of range, clamped on load
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] pick_vec();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(20'hFFFFF)) - 20'sh80000) <<< 4;
        endcase
    endfunction

    function automatic logic [15:0] pick_bias();
        case ($urandom_range(7))
            0: return 16'd32768;
            1: return 16'hFFFF;
            2: return 16'd0;
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // Send one item and hold it until accepted; idle first at random.
    task automatic send(logic cmd, logic [5:0] j, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, logic [63:0] q, logic [15:0] bias, logic last);
        while (!quiet_stretch && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, bias, q, z, y, x, j, cmd};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_joint(logic [5:0] j);
        send(wvs_pkg::CMD_LOAD, j, pick_vec(), pick_vec(), pick_vec(),
             {pick_quat(), pick_quat(), pick_quat(), pick_quat()}, 16'($urandom),
             1'($urandom));
        loaded[j] = 1'b1;
    endtask

    task automatic weight(logic [5:0] j, logic last);
        send(wvs_pkg::CMD_WEIGHT, j, pick_vec(), pick_vec(), pick_vec(), 64'($urandom),
             pick_bias(), last);
    endtask

    function automatic logic [5:0] loaded_joint();
        logic [5:0] j;
        do j = 6'($urandom); while (!loaded[j]);
        return j;
    endfunction

    initial begin
        int items;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes of joints, quaternions, offsets and bias
        send(wvs_pkg::CMD_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
             {16'sd16384, 16'h0, 16'h0, 16'h0}, 16'h0, 1'b1);
        send(wvs_pkg::CMD_LOAD, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             {16'h7FFF, 16'h8000, 16'hC000, 16'h4000}, 16'hFFFF, 1'b0);
        send(wvs_pkg::CMD_LOAD, 6'd1, 32'h0001_0000, 32'h0, 32'h0,
             {16'sd11585, 16'h0, 16'h0, 16'sd11585}, 16'h0, 1'b0);
        loaded[0] = 1; loaded[63] = 1; loaded[1] = 1;
        send(wvs_pkg::CMD_WEIGHT, 6'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0,
             16'd32768, 1'b1);
        send(wvs_pkg::CMD_WEIGHT, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1,
             16'hFFFF, 1'b0);
        send(wvs_pkg::CMD_WEIGHT, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0,
             16'hFFFF, 1'b0);
        send(wvs_pkg::CMD_WEIGHT, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0,
             16'hFFFF, 1'b1);
        send(wvs_pkg::CMD_WEIGHT, 6'd1, 32'h8000_0000, 32'h0, 32'h0001_0000, '0,
             16'd0, 1'b1);
        send(wvs_pkg::CMD_WEIGHT, 6'd1, 32'h0000_8000, 32'hFFFF_8000, 32'h0, '0,
             16'd1, 1'b1);
        for (int k = 0; k < 64; k++) load_joint(6'(k));
        items = 9 + 64;
        while (items < 760) begin
            // hold off until the output drains, whenever the item count is just past 300
            if (items > 300 && items < 310) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (vertices_pending != 0) @(posedge aclk);
            end
            quiet_stretch = (items > 450 && items < 560);
            if ($urandom_range(9) == 0) begin
                load_joint(6'($urandom));
                items++;
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) weight(loaded_joint(), k == n - 1);
                items += n;
            end
        end
        quiet_stretch = 1'b0;
        s_tvalid <= 1'b0;
        while (vertices_pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
